### rtl/core/lbmc_pkg.sv
// Shared codes and constants for the LED blink mode classifier.
// Depends on nothing; imported by led_blink_mode_classifier, lbmc_mode_checker and tb.
`timescale 1ns / 1ps

package lbmc_pkg;

	// Field widths fixed by the interface.
	localparam int SIG_W   = 2;
	localparam int NOW_W   = 32;
	localparam int MODE_W  = 2;
	localparam int CFG_W   = 16;
	localparam int COUNT_W = 4;
	localparam int IDX_W   = 3;

	// Sampled signal codes. The unused code is treated as low.
	localparam logic [SIG_W-1:0] SIG_LOW   = 2'd0;
	localparam logic [SIG_W-1:0] SIG_HIGH  = 2'd1;
	localparam logic [SIG_W-1:0] SIG_BLINK = 2'd2;

	// Reported modes.
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MIN_HALF  = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_HALF  = 3'd1;
	localparam logic [IDX_W-1:0] REG_EDGES_REQ = 3'd2;
	localparam logic [IDX_W-1:0] REG_STALE     = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFF_IGN   = 3'd4;

	// Register values after reset.
	localparam logic [CFG_W-1:0]   RST_MIN_HALF  = 16'd100;
	localparam logic [CFG_W-1:0]   RST_MAX_HALF  = 16'd1000;
	localparam logic [COUNT_W-1:0] RST_EDGES_REQ = 4'd4;
	localparam logic [CFG_W-1:0]   RST_STALE     = 16'd2000;
	localparam logic [CFG_W-1:0]   RST_OFF_IGN   = 16'd500;

endpackage

### rtl/core/led_blink_mode_classifier.sv
// LED blink mode classifier: input register, combinational state update, result register.
// Depends on lbmc_pkg for signal, mode and register codes.
`timescale 1ns / 1ps

// The classifier takes one LED sample per request on the sample channel, each a signal
// state (low, high, or blinking already detected) and a millisecond timestamp, and returns
// one request on the mode channel with the LED mode (off, on or blinking) at that timestamp.
// A new sample is accepted on every clock while the mode channel keeps taking results, so
// the sustained rate is one sample per cycle. A sample is held in the input register
// until the result register frees up; its result is then written to the result
// register and offered on the mode channel. The rate rests on the tracking-state update,
// which works out the level, time stamps and edge counter combinationally and writes
// them together with the result, so the following sample always sees the updated state.
// Timestamps are used modulo 2^TIME_BITS: narrower settings drop the upper bits of now_ms,
// wider ones zero-extend it. Configuration registers should be written only while no sample
// is in flight; an index above the last register is ignored.
module led_blink_mode_classifier
	import lbmc_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_wen,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	// Sample channel.
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [SIG_W-1:0]   signal_state,
	input  logic [NOW_W-1:0]   now_ms,
	// Mode channel.
	output logic               mode_valid,
	input  logic               mode_stall,
	output logic [MODE_W-1:0]  led_mode
);

	// Configuration registers.
	logic [CFG_W-1:0]   min_half_q;
	logic [CFG_W-1:0]   max_half_q;
	logic [COUNT_W-1:0] edges_req_q;
	logic [CFG_W-1:0]   stale_q;
	logic [CFG_W-1:0]   off_ign_q;

	// Tracking state.
	logic                 last_level_q;
	logic                 init_q;
	logic                 seen_on_q;
	logic [TIME_BITS-1:0] last_change_q;
	logic [TIME_BITS-1:0] last_on_q;
	logic [TIME_BITS-1:0] last_edge_q;
	logic [COUNT_W-1:0]   edge_count_q;

	// Input register and result register.
	logic                 valid_s1;
	logic [SIG_W-1:0]     sig_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 valid_s2;
	logic [MODE_W-1:0]    mode_s2;

	// Next tracking state and mode for the sample held in the input register.
	logic                 level_n;
	logic                 seen_on_n;
	logic [TIME_BITS-1:0] last_change_n;
	logic [TIME_BITS-1:0] last_on_n;
	logic [TIME_BITS-1:0] last_edge_n;
	logic [COUNT_W-1:0]   edge_count_n;
	logic                 is_high;
	logic                 is_blink;
	logic [TIME_BITS-1:0] gap;
	logic [TIME_BITS-1:0] edge_age;
	logic [TIME_BITS-1:0] on_age;
	logic                 in_window;
	logic [MODE_W-1:0]    mode_n;

	logic advance;
	logic update;

	// The result register frees up whenever it is empty or its request is taken.
	assign advance      = !(valid_s2 && mode_stall);
	assign update       = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	assign mode_valid = valid_s2;
	assign led_mode   = mode_s2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_half_q  <= RST_MIN_HALF;
			max_half_q  <= RST_MAX_HALF;
			edges_req_q <= RST_EDGES_REQ;
			stale_q     <= RST_STALE;
			off_ign_q   <= RST_OFF_IGN;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MIN_HALF:  min_half_q  <= cfg_wdata;
				REG_MAX_HALF:  max_half_q  <= cfg_wdata;
				REG_EDGES_REQ: edges_req_q <= cfg_wdata[COUNT_W-1:0];
				REG_STALE:     stale_q     <= cfg_wdata;
				REG_OFF_IGN:   off_ign_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input register: takes a new sample whenever it is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sig_s1 <= signal_state;
			now_s1 <= TIME_BITS'(now_ms);
		end
	end

	// State update for the sample in the input register.
	always_comb begin
		is_high  = (sig_s1 == SIG_HIGH);
		is_blink = (sig_s1 == SIG_BLINK);
		gap      = now_s1 - last_change_q;
		in_window = (gap >= TIME_BITS'(min_half_q)) && (gap <= TIME_BITS'(max_half_q));

		level_n       = last_level_q;
		seen_on_n     = seen_on_q;
		last_change_n = last_change_q;
		last_on_n     = last_on_q;
		last_edge_n   = last_edge_q;
		edge_count_n  = edge_count_q;

		if (is_blink) begin
			// Blinking reported upstream: counter full, edge and high time now.
			seen_on_n    = 1'b1;
			last_on_n    = now_s1;
			last_edge_n  = now_s1;
			edge_count_n = edges_req_q;
		end else if (!init_q) begin
			// The first sample only records the level, its time and, if high, the high time.
			level_n       = is_high;
			last_change_n = now_s1;
			if (is_high) begin
				seen_on_n = 1'b1;
				last_on_n = now_s1;
			end
		end else begin
			if (is_high) begin
				seen_on_n = 1'b1;
				last_on_n = now_s1;
			end
			if (is_high != last_level_q) begin
				if (in_window) begin
					if (edge_count_q < edges_req_q) begin
						edge_count_n = edge_count_q + COUNT_W'(1);
					end
					last_edge_n = now_s1;
				end else begin
					edge_count_n = '0;
				end
				level_n       = is_high;
				last_change_n = now_s1;
			end
		end
	end

	// Mode at the sample's timestamp, from the updated state.
	always_comb begin
		edge_age = now_s1 - last_edge_n;
		on_age   = now_s1 - last_on_n;
		if ((edge_count_n >= edges_req_q) && (edge_age <= TIME_BITS'(stale_q))) begin
			mode_n = MODE_BLINK;
		end else if (level_n) begin
			mode_n = MODE_ON;
		end else if (seen_on_n && (on_age < TIME_BITS'(off_ign_q))) begin
			mode_n = MODE_ON;
		end else begin
			mode_n = MODE_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b0;
			init_q        <= 1'b0;
			seen_on_q     <= 1'b0;
			last_change_q <= '0;
			last_on_q     <= '0;
			last_edge_q   <= '0;
			edge_count_q  <= '0;
		end else if (update) begin
			last_level_q  <= level_n;
			init_q        <= 1'b1;
			seen_on_q     <= seen_on_n;
			last_change_q <= last_change_n;
			last_on_q     <= last_on_n;
			last_edge_q   <= last_edge_n;
			edge_count_q  <= edge_count_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			mode_s2 <= mode_n;
		end
	end

	// A sample reported as blinking always classifies as blinking.
	a_blink_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(update && sig_s1 == SIG_BLINK) |=> (mode_s2 == MODE_BLINK))
		else $error("blinking sample did not report blinking");

	// A high sample can never classify as off.
	a_high_not_off: assert property (@(posedge clk) disable iff (!arst_n)
		(update && sig_s1 == SIG_HIGH) |=> (mode_s2 != MODE_OFF))
		else $error("high sample reported off");

	// The input side only stalls when both registers hold a sample.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2))
		else $error("sample stalled with room in the pipeline");

	// Any processed sample leaves the tracker initialised.
	a_init_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		update |=> init_q)
		else $error("tracker not initialised after a sample");

endmodule

### dv/lbmc_mode_checker.sv
// Checker for the LED blink mode classifier: watches the sample, mode and register ports,
// tracks the LED state itself and compares every returned mode. Depends on lbmc_pkg.
`timescale 1ns / 1ps

module lbmc_mode_checker
	import lbmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  logic [SIG_W-1:0]  signal_state,
	input  logic [NOW_W-1:0]  now_ms,
	input  logic              mode_valid,
	input  logic              mode_stall,
	input  logic [MODE_W-1:0] led_mode,
	output int                fail_count,
	output int                pending
);

	// Register copies.
	logic [CFG_W-1:0]   min_half, max_half, stale_lim, off_lim;
	logic [COUNT_W-1:0] edges_req;

	// Tracked LED state.
	logic               level_now, armed, seen_high;
	logic [NOW_W-1:0]   chg_time, high_time, edge_time;
	logic [COUNT_W-1:0] edge_cnt;

	logic [MODE_W-1:0]  modes_due[$];
	logic [MODE_W-1:0]  new_mode, due_mode;
	int                 mismatches = 0;

	// Applies one sample to the tracked state and works out the mode it reports.
	task automatic track_sample(input logic [SIG_W-1:0] sig, input logic [NOW_W-1:0] t,
			output logic [MODE_W-1:0] mode);
		logic             high;
		logic [NOW_W-1:0] gap;
		high = (sig == SIG_HIGH);
		if (sig == SIG_BLINK) begin
			armed     = 1'b1;
			seen_high = 1'b1;
			high_time = t;
			edge_time = t;
			edge_cnt  = edges_req;
		end else if (!armed) begin
			armed     = 1'b1;
			level_now = high;
			chg_time  = t;
			if (high) begin
				seen_high = 1'b1;
				high_time = t;
			end
		end else begin
			if (high) begin
				seen_high = 1'b1;
				high_time = t;
			end
			if (high != level_now) begin
				gap = t - chg_time;
				if (gap >= min_half && gap <= max_half) begin
					if (edge_cnt < edges_req)
						edge_cnt = edge_cnt + 1'b1;
					edge_time = t;
				end else begin
					edge_cnt = '0;
				end
				level_now = high;
				chg_time  = t;
			end
		end
		if (edge_cnt >= edges_req && NOW_W'(t - edge_time) <= stale_lim)
			mode = MODE_BLINK;
		else if (level_now)
			mode = MODE_ON;
		else if (seen_high && NOW_W'(t - high_time) < off_lim)
			mode = MODE_ON;
		else
			mode = MODE_OFF;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_half  = RST_MIN_HALF;
			max_half  = RST_MAX_HALF;
			edges_req = RST_EDGES_REQ;
			stale_lim = RST_STALE;
			off_lim   = RST_OFF_IGN;
			level_now = 1'b0;
			armed     = 1'b0;
			seen_high = 1'b0;
			chg_time  = '0;
			high_time = '0;
			edge_time = '0;
			edge_cnt  = '0;
			modes_due.delete();
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_MIN_HALF:  min_half  = cfg_wdata;
					REG_MAX_HALF:  max_half  = cfg_wdata;
					REG_EDGES_REQ: edges_req = cfg_wdata[COUNT_W-1:0];
					REG_STALE:     stale_lim = cfg_wdata;
					REG_OFF_IGN:   off_lim   = cfg_wdata;
					default:       ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				track_sample(signal_state, now_ms, new_mode);
				modes_due.push_back(new_mode);
			end
			if (mode_valid && !mode_stall) begin
				if (modes_due.size() == 0) begin
					$error("led_mode: no result expected, got %0d", led_mode);
					mismatches++;
				end else begin
					due_mode = modes_due.pop_front();
					if (led_mode !== due_mode) begin
						$error("led_mode: expected %0d, got %0d", due_mode, led_mode);
						mismatches++;
					end
				end
			end
			pending    <= modes_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

### dv/tb.sv
// Top of the LED blink mode classifier testbench: clock, reset, sample stimulus, mode
// channel back-pressure and the verdict. Depends on lbmc_pkg, lbmc_mode_checker and the block.
`timescale 1ns / 1ps

module tb;
	import lbmc_pkg::*;

	// The fourth signal code has no meaning of its own; the block must treat it as low.
	localparam logic [SIG_W-1:0] SIG_UNUSED = 2'd3;

	logic clk = 1'b0;
	always #5 clk = ~clk;

	logic              arst_n;
	logic              cfg_wen;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              sample_valid;
	logic              sample_stall;
	logic [SIG_W-1:0]  signal_state;
	logic [NOW_W-1:0]  now_ms;
	logic              mode_valid;
	logic              mode_stall;
	logic [MODE_W-1:0] led_mode;
	int                fail_count;
	int                pending;

	led_blink_mode_classifier dut (.*);
	lbmc_mode_checker checker_i (.*);

	// Register values last written, kept here only to shape the sample timing around the
	// blink window and the stale and off-ignore limits.
	logic [CFG_W-1:0]   cur_min, cur_max, cur_stale, cur_off;

	// Current sample time and LED level on the stimulus side.
	logic [NOW_W-1:0] t_ms;
	logic             lvl;
	int               sent = 0;

	// When set, the sender or the receiver stops idling. The receiver's long hold-off is
	// requested by bumping hold_asked; the receiver process serves it in its own time.
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int hold_asked = 0;
	int hold_served = 0;

	// Offers one sample request and returns at the edge that accepts it. Valid stays high on
	// return, so a following request is offered back to back unless a random gap is taken.
	task automatic send_sample(input logic [SIG_W-1:0] sig, input logic [NOW_W-1:0] stamp);
		if (!tx_calm && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		signal_state <= sig;
		now_ms       <= stamp;
		do @(posedge clk); while (sample_stall);
		sent++;
	endtask

	task automatic step(input logic [SIG_W-1:0] sig, input logic [NOW_W-1:0] delta);
		t_ms = t_ms + delta;
		send_sample(sig, t_ms);
	endtask

	// Stops offering samples and waits until every mode request has been returned.
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only written once the block has nothing in flight.
	task automatic program_regs(input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] mx,
			input logic [COUNT_W-1:0] ed, input logic [CFG_W-1:0] st,
			input logic [CFG_W-1:0] of);
		drain();
		write_reg(REG_MIN_HALF, mn);
		write_reg(REG_MAX_HALF, mx);
		write_reg(REG_EDGES_REQ, CFG_W'(ed));
		write_reg(REG_STALE, st);
		write_reg(REG_OFF_IGN, of);
		cur_min   = mn;
		cur_max   = mx;
		cur_stale = st;
		cur_off   = of;
	endtask

	// Low is now and then sent as the unused code, which must behave the same way.
	function automatic logic [SIG_W-1:0] level_code(input logic high);
		if (high)
			return SIG_HIGH;
		return ($urandom_range(0, 5) == 0) ? SIG_UNUSED : SIG_LOW;
	endfunction

	// Half period of the next level change: mostly inside the blink window, sometimes on
	// its very boundaries and sometimes just outside, which clears the edge counter.
	function automatic logic [NOW_W-1:0] pick_half();
		int r;
		r = $urandom_range(0, 9);
		if (cur_min <= cur_max && r == 0)
			return NOW_W'(cur_min);
		if (cur_min <= cur_max && r == 1)
			return NOW_W'(cur_max);
		if (cur_min <= cur_max && r < 8)
			return $urandom_range(cur_max, cur_min);
		if (cur_min > 0 && r == 8)
			return $urandom_range(cur_min - 1, 0);
		return NOW_W'(cur_max) + 1 + $urandom_range(0, 500);
	endfunction

	// Time to the next sample after a train: aimed at the stale and off-ignore limits.
	function automatic logic [NOW_W-1:0] tail_gap();
		case ($urandom_range(0, 5))
			0:       return NOW_W'(cur_stale);
			1:       return NOW_W'(cur_stale) + 1;
			2:       return NOW_W'(cur_off);
			3:       return NOW_W'(cur_off) - 1;
			4:       return NOW_W'(cur_off) + 1;
			default: return $urandom_range(0, 70000);
		endcase
	endfunction

	// A run of level changes paced to look like a blinking LED, with repeated samples of
	// the same level in between now and then, followed by a few samples as it settles.
	task automatic blink_train();
		logic [NOW_W-1:0] half;
		int               changes;
		changes = $urandom_range(3, 18);
		repeat (changes) begin
			half = pick_half();
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 2))
					send_sample(level_code(lvl), t_ms + $urandom_range(0, half));
			end
			lvl = ~lvl;
			step(level_code(lvl), half);
		end
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1) == 0)
				lvl = 1'b0;
			step(level_code(lvl), tail_gap());
		end
	endtask

	task automatic noise();
		logic [SIG_W-1:0] sig;
		repeat ($urandom_range(1, 4)) begin
			sig = SIG_W'($urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0:       t_ms = t_ms + $urandom_range(0, 200);
				1:       t_ms = t_ms + $urandom_range(0, 140000);
				default: t_ms = $urandom;
			endcase
			send_sample(sig, t_ms);
			if (sig == SIG_HIGH)
				lvl = 1'b1;
			else if (sig != SIG_BLINK)
				lvl = 1'b0;
		end
	endtask

	// Mostly well-formed blink trains, with samples that already report blinking and with
	// random noise mixed in.
	task automatic run_mix(input int count);
		int goal;
		int r;
		goal = sent + count;
		while (sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				blink_train();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3))
					step(SIG_BLINK, $urandom_range(0, 3000));
			end else begin
				noise();
			end
		end
	endtask

	// Receiver side: random stall bursts, stretches with no stall, and the long hold-off on
	// request, during which the sender keeps offering so that the block backs up.
	initial begin
		forever begin
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				mode_stall <= 1'b1;
				repeat (80) @(posedge clk);
			end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
				mode_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				mode_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Main stimulus.
	initial begin
		arst_n       <= 1'b0;
		cfg_wen      <= 1'b0;
		cfg_index    <= REG_MIN_HALF;
		cfg_wdata    <= '0;
		sample_valid <= 1'b0;
		signal_state <= SIG_LOW;
		now_ms       <= '0;
		cur_min   = RST_MIN_HALF;
		cur_max   = RST_MAX_HALF;
		cur_stale = RST_STALE;
		cur_off   = RST_OFF_IGN;
		lvl       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples under the reset settings. The first one only sets the level; the
		// times start just short of the wrap so the early edges are measured across it.
		t_ms = 32'hFFFF_FF00;
		send_sample(SIG_HIGH, t_ms);
		step(SIG_LOW, 300);
		step(SIG_HIGH, NOW_W'(RST_MIN_HALF));
		step(SIG_UNUSED, NOW_W'(RST_MAX_HALF));
		step(SIG_HIGH, 400);
		// Blinking holds up to the stale limit and lapses one millisecond later.
		step(SIG_HIGH, NOW_W'(RST_STALE));
		step(SIG_HIGH, 1);
		// A change after too long a gap clears the count.
		step(SIG_LOW, NOW_W'(RST_MAX_HALF) + 1);
		// A short on pulse: the off time that follows is still reported as on until the
		// off-ignore limit is reached.
		step(SIG_HIGH, 50);
		step(SIG_LOW, NOW_W'(RST_OFF_IGN) - 1);
		step(SIG_LOW, 1);
		// A sample that reports blinking already detected fills the counter at once.
		step(SIG_BLINK, 7);
		step(SIG_LOW, NOW_W'(RST_STALE) + 1);
		step(SIG_LOW, 0);
		t_ms = '1;
		send_sample(SIG_HIGH, t_ms);
		step(SIG_LOW, 1);

		// Inverted window together with no edge requirement: no change is ever an edge,
		// and blinking depends on the age of the last edge alone.
		program_regs(16'd500, 16'd200, 4'd0, 16'd100, 16'd0);
		step(SIG_LOW, 50);
		step(SIG_HIGH, 300);
		step(SIG_BLINK, 1000);
		step(SIG_LOW, 100);
		step(SIG_LOW, 1);
		// Writes to the indexes past the last register must leave everything unchanged.
		drain();
		for (int i = REG_OFF_IGN + 1; i < 2 ** IDX_W; i++)
			write_reg(IDX_W'(i), '1);
		step(SIG_HIGH, 60);
		step(SIG_LOW, 101);

		// Random phases, each under its own settings, the extremes among them.
		program_regs(RST_MIN_HALF, RST_MAX_HALF, RST_EDGES_REQ, RST_STALE, RST_OFF_IGN);
		run_mix(80);
		program_regs('1, '1, '1, '1, '1);
		run_mix(40);
		// Pause the sender until every mode request has come back, then carry on.
		drain();
		run_mix(40);
		program_regs(16'd0, '1, 4'd15, '1, '1);
		// Long receiver hold-off while the sender keeps offering back to back.
		hold_asked++;
		tx_calm = 1'b1;
		repeat (3) blink_train();
		tx_calm = 1'b0;
		run_mix(60);
		program_regs('0, '0, 4'd1, '0, '0);
		run_mix(80);
		program_regs(16'd500, 16'd200, 4'd3, 16'd1000, 16'd100);
		run_mix(70);
		program_regs(16'd50, 16'd300, 4'd0, 16'd800, 16'd250);
		run_mix(70);
		repeat (2) begin
			program_regs(CFG_W'($urandom_range(0, 1500)), CFG_W'($urandom_range(200, 4000)),
				COUNT_W'($urandom_range(1, 15)), CFG_W'($urandom_range(0, 65535)),
				CFG_W'($urandom_range(0, 3000)));
			run_mix(80);
		end

		// Last stretch with no idling on either side.
		program_regs(RST_MIN_HALF, RST_MAX_HALF, RST_EDGES_REQ, RST_STALE, RST_OFF_IGN);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_mix(70);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("led_blink_mode_classifier regression: pass");
		else
			$display("led_blink_mode_classifier regression: fail");
		$finish;
	end

	// Guard against a hung handshake or a mode request that never comes back.
	initial begin
		#5_000_000;
		$display("led_blink_mode_classifier regression: fail");
		$finish;
	end

endmodule

### led_blink_mode_classifier.f
rtl/core/lbmc_pkg.sv
rtl/core/led_blink_mode_classifier.sv
dv/lbmc_mode_checker.sv
dv/tb.sv
